// ===== hdl/aarm_pkg.sv =====
// ----------------------------------------------------------------------------
// aarm_pkg
// Types and constants shared by the axis-angle rotation matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // Q30 working values, wide enough for an angle of up to 8 rad
  typedef logic signed [35:0] val_t;

  localparam val_t PI_Q30          = 36'sd3373259426;
  localparam val_t HALF_PI_Q30     = 36'sd1686629713;
  localparam val_t TWO_PI_Q30      = 36'sd6746518852;
  localparam val_t ONE_Q30         = 36'sd1073741824;
  localparam val_t CORDIC_GAIN_INV = 36'sd652032874;

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int MUL_STEPS  = 15;

  // classified item handed from front to back
  typedef struct packed {
    logic               axis_zero;
    logic [31:0]        sum_sq;
    val_t               angle;
    logic               angle_neg;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } back_state_t;

  function automatic val_t atan_q30(input logic [4:0] i);
    val_t r;
    case (i)
      5'd0:  r = 36'sd843314856;
      5'd1:  r = 36'sd497837829;
      5'd2:  r = 36'sd263043836;
      5'd3:  r = 36'sd133525158;
      5'd4:  r = 36'sd67021686;
      5'd5:  r = 36'sd33543515;
      5'd6:  r = 36'sd16775850;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194282;
      5'd9:  r = 36'sd2097149;
      5'd10: r = 36'sd1048575;
      5'd11: r = 36'sd524287;
      5'd12: r = 36'sd262143;
      5'd13: r = 36'sd131071;
      5'd14: r = 36'sd65535;
      5'd15: r = 36'sd32767;
      5'd16: r = 36'sd16383;
      5'd17: r = 36'sd8191;
      5'd18: r = 36'sd4095;
      5'd19: r = 36'sd2047;
      5'd20: r = 36'sd1023;
      5'd21: r = 36'sd511;
      5'd22: r = 36'sd255;
      5'd23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/aarm_if.sv =====
// ----------------------------------------------------------------------------
// aarm interfaces
// Valid/ready channels for the axis items and the matrix column beats.
// ----------------------------------------------------------------------------
interface aarm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         column_index;
  logic signed [15:0] elem0;
  logic signed [15:0] elem1;
  logic signed [15:0] elem2;
  logic signed [15:0] elem3;
  logic               last_column;
  logic               axis_zero;

  modport source (output valid, column_index, elem0, elem1, elem2, elem3, last_column,
                  axis_zero, input ready);
  modport sink   (input valid, column_index, elem0, elem1, elem2, elem3, last_column,
                  axis_zero, output ready);
endinterface

// ===== hdl/aarm_front.sv =====
// ----------------------------------------------------------------------------
// aarm_front
// Takes input beats, flags a zero axis, forms the squared norm and reduces
// the angle to [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module aarm_front (
  aarm_in_if.sink          in_item,
  input  logic             q_full,
  output logic             q_push,
  output aarm_pkg::job_t   q_job
);

  aarm_pkg::val_t a0, a1;
  logic [31:0]    sx, sy, sz;

  assign in_item.ready = !q_full;
  assign q_push        = in_item.valid && !q_full;

  always_comb begin
    sx = 32'(in_item.axis_x * in_item.axis_x);
    sy = 32'(in_item.axis_y * in_item.axis_y);
    sz = 32'(in_item.axis_z * in_item.axis_z);
    a0 = aarm_pkg::val_t'(in_item.angle) <<< 18;
    if (a0 > aarm_pkg::PI_Q30) begin
      a1 = a0 - aarm_pkg::TWO_PI_Q30;
    end else if (a0 < -aarm_pkg::PI_Q30) begin
      a1 = a0 + aarm_pkg::TWO_PI_Q30;
    end else begin
      a1 = a0;
    end
    q_job.axis_zero = (in_item.axis_x == '0) && (in_item.axis_y == '0) &&
                      (in_item.axis_z == '0);
    q_job.sum_sq    = sx + sy + sz;
    // fold into the right half plane, cos and sin change sign
    if (a1 > aarm_pkg::HALF_PI_Q30) begin
      q_job.angle     = a1 - aarm_pkg::PI_Q30;
      q_job.angle_neg = 1'b1;
    end else if (a1 < -aarm_pkg::HALF_PI_Q30) begin
      q_job.angle     = a1 + aarm_pkg::PI_Q30;
      q_job.angle_neg = 1'b1;
    end else begin
      q_job.angle     = a1;
      q_job.angle_neg = 1'b0;
    end
    q_job.ax = in_item.axis_x;
    q_job.ay = in_item.axis_y;
    q_job.az = in_item.axis_z;
  end

endmodule

// ===== hdl/aarm_queue.sv =====
// ----------------------------------------------------------------------------
// aarm_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module aarm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aarm_pkg::job_t   push_job,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output aarm_pkg::job_t   head_job
);

  aarm_pkg::job_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign avail    = (count_r != 2'd0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/aarm_back.sv =====
// ----------------------------------------------------------------------------
// aarm_back
// Square root, axis normalisation, CORDIC, shared multiplier and column
// output register.
// ----------------------------------------------------------------------------
module aarm_back #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int ENTRY_WIDTH     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_avail,
  input  aarm_pkg::job_t   q_job,
  output logic             q_pop,
  aarm_out_if.source       out_item
);

  localparam int SH = 32 - ENTRY_WIDTH;
  localparam logic signed [39:0] RND    = 40'sd1 <<< SH >>> 1;
  localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (ENTRY_WIDTH - 1)) - 40'sd1;
  localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

  function automatic logic [15:0] to_entry(input aarm_pkg::val_t v);
    logic signed [39:0] r;
    r = (40'(v) + RND) >>> SH;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[15:0];
  endfunction

  aarm_pkg::back_state_t state_r, state_nxt;

  typedef struct packed {
    logic pop;
    logic root_step;
    logic div_step;
    logic mul_step;
    logic emit;
  } ctl_t;
  ctl_t ctl;

  aarm_pkg::job_t job_r;
  logic [4:0]     cnt_r;
  logic [1:0]     col_r;
  logic [63:0]    rad_r, res_r, bit_r;
  aarm_pkg::val_t cx_r, cy_r, cz_r;
  aarm_pkg::val_t c_r, s_r;
  logic [31:0]    rem_r [3];
  logic [30:0]    quo_r [3];
  aarm_pkg::val_t pr_r [9];

  logic           out_valid_r;
  logic [1:0]     out_col_r;
  logic [15:0]    out_e_r [4];
  logic           out_zero_r;

  logic           out_free, last_root, last_div, last_mul, last_col;
  logic [63:0]    rsum;
  logic           rge;
  aarm_pkg::val_t u_w [3];
  logic signed [15:0] comp [3];
  aarm_pkg::val_t ci, op_a, op_b;
  logic signed [71:0] prod;
  logic [3:0]     dst;
  aarm_pkg::val_t m_w [4];

  assign out_free  = !out_valid_r || out_item.ready;
  assign last_root = (cnt_r == 5'(aarm_pkg::ROOT_STEPS - 1));
  assign last_div  = (cnt_r == 5'(aarm_pkg::DIV_STEPS - 1));
  assign last_mul  = (cnt_r == 5'(aarm_pkg::MUL_STEPS - 1));
  assign last_col  = (col_r == 2'd3);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aarm_pkg::ST_IDLE: begin
        if (q_avail) begin
          state_nxt = q_job.axis_zero ? aarm_pkg::ST_EMIT : aarm_pkg::ST_ROOT;
        end
      end
      aarm_pkg::ST_ROOT: if (last_root) state_nxt = aarm_pkg::ST_DIV;
      aarm_pkg::ST_DIV:  if (last_div) state_nxt = aarm_pkg::ST_MUL;
      aarm_pkg::ST_MUL:  if (last_mul) state_nxt = aarm_pkg::ST_EMIT;
      aarm_pkg::ST_EMIT: if (out_free && last_col) state_nxt = aarm_pkg::ST_IDLE;
      default:           state_nxt = aarm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      aarm_pkg::ST_IDLE: ctl.pop       = q_avail;
      aarm_pkg::ST_ROOT: ctl.root_step = 1'b1;
      aarm_pkg::ST_DIV:  ctl.div_step  = 1'b1;
      aarm_pkg::ST_MUL:  ctl.mul_step  = 1'b1;
      aarm_pkg::ST_EMIT: ctl.emit      = out_free;
      default:           ctl = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  always_comb begin
    rsum = res_r + bit_r;
    rge  = (rad_r >= rsum);
    comp[0] = job_r.ax;
    comp[1] = job_r.ay;
    comp[2] = job_r.az;
    for (int k = 0; k < 3; k++) begin
      u_w[k] = comp[k][15] ? -aarm_pkg::val_t'(quo_r[k]) : aarm_pkg::val_t'(quo_r[k]);
    end
    ci = aarm_pkg::ONE_Q30 - c_r;
    op_a = '0;
    op_b = '0;
    dst  = 4'(cnt_r);
    case (cnt_r)
      5'd0:  begin op_a = u_w[0]; op_b = u_w[0]; end
      5'd1:  begin op_a = u_w[1]; op_b = u_w[1]; end
      5'd2:  begin op_a = u_w[2]; op_b = u_w[2]; end
      5'd3:  begin op_a = u_w[0]; op_b = u_w[1]; end
      5'd4:  begin op_a = u_w[0]; op_b = u_w[2]; end
      5'd5:  begin op_a = u_w[1]; op_b = u_w[2]; end
      5'd6:  begin op_a = pr_r[0]; op_b = ci; dst = 4'd0; end
      5'd7:  begin op_a = pr_r[1]; op_b = ci; dst = 4'd1; end
      5'd8:  begin op_a = pr_r[2]; op_b = ci; dst = 4'd2; end
      5'd9:  begin op_a = pr_r[3]; op_b = ci; dst = 4'd3; end
      5'd10: begin op_a = pr_r[4]; op_b = ci; dst = 4'd4; end
      5'd11: begin op_a = pr_r[5]; op_b = ci; dst = 4'd5; end
      5'd12: begin op_a = u_w[0]; op_b = s_r; dst = 4'd6; end
      5'd13: begin op_a = u_w[1]; op_b = s_r; dst = 4'd7; end
      5'd14: begin op_a = u_w[2]; op_b = s_r; dst = 4'd8; end
      default: begin op_a = '0; op_b = '0; dst = 4'd0; end
    endcase
    // operands stay within 34 bits
    prod = 72'($signed(op_a[33:0]) * $signed(op_b[33:0]));
  end

  // pr order: xx yy zz xy xz yz xs ys zs
  always_comb begin
    m_w[3] = '0;
    case (col_r)
      2'd0: begin
        m_w[0] = c_r + pr_r[0];
        m_w[1] = pr_r[3] + pr_r[8];
        m_w[2] = pr_r[4] - pr_r[7];
      end
      2'd1: begin
        m_w[0] = pr_r[3] - pr_r[8];
        m_w[1] = c_r + pr_r[1];
        m_w[2] = pr_r[5] + pr_r[6];
      end
      2'd2: begin
        m_w[0] = pr_r[4] + pr_r[7];
        m_w[1] = pr_r[5] - pr_r[6];
        m_w[2] = c_r + pr_r[2];
      end
      default: begin
        m_w[0] = '0;
        m_w[1] = '0;
        m_w[2] = '0;
        m_w[3] = aarm_pkg::ONE_Q30;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aarm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      job_r <= q_job;
      cnt_r <= '0;
      col_r <= '0;
      rad_r <= {q_job.sum_sq, 32'd0};
      res_r <= '0;
      bit_r <= 64'd1 << 62;
      cx_r  <= aarm_pkg::CORDIC_GAIN_INV;
      cy_r  <= '0;
      cz_r  <= q_job.angle;
      // identity falls out of the column sums with c = 1 and no products
      c_r   <= aarm_pkg::ONE_Q30;
      s_r   <= '0;
      for (int k = 0; k < 9; k++) begin
        pr_r[k] <= '0;
      end
    end
    if (ctl.root_step) begin
      cnt_r <= last_root ? 5'd0 : cnt_r + 5'd1;
      rad_r <= rge ? rad_r - rsum : rad_r;
      res_r <= rge ? (res_r >> 1) + bit_r : res_r >> 1;
      bit_r <= bit_r >> 2;
      if (cnt_r < 5'(TRIG_ITERATIONS)) begin
        if (cz_r >= 0) begin
          cx_r <= cx_r - (cy_r >>> cnt_r);
          cy_r <= cy_r + (cx_r >>> cnt_r);
          cz_r <= cz_r - aarm_pkg::atan_q30(cnt_r);
        end else begin
          cx_r <= cx_r + (cy_r >>> cnt_r);
          cy_r <= cy_r - (cx_r >>> cnt_r);
          cz_r <= cz_r + aarm_pkg::atan_q30(cnt_r);
        end
      end
      if (last_root) begin
        c_r <= job_r.angle_neg ? -cx_r : cx_r;
        s_r <= job_r.angle_neg ? -cy_r : cy_r;
        for (int k = 0; k < 3; k++) begin
          rem_r[k] <= 32'(comp[k][15] ? -17'(comp[k]) : 17'(comp[k])) << 15;
          quo_r[k] <= '0;
        end
      end
    end
    if (ctl.div_step) begin
      cnt_r <= last_div ? 5'd0 : cnt_r + 5'd1;
      for (int k = 0; k < 3; k++) begin
        if ({rem_r[k], 1'b0} >= {1'b0, res_r[31:0]}) begin
          rem_r[k] <= 32'({rem_r[k], 1'b0} - {1'b0, res_r[31:0]});
          quo_r[k] <= {quo_r[k][29:0], 1'b1};
        end else begin
          rem_r[k] <= {rem_r[k][30:0], 1'b0};
          quo_r[k] <= {quo_r[k][29:0], 1'b0};
        end
      end
    end
    if (ctl.mul_step) begin
      cnt_r     <= cnt_r + 5'd1;
      pr_r[dst] <= aarm_pkg::val_t'(prod >>> 30);
    end
    if (ctl.emit) begin
      col_r      <= col_r + 2'd1;
      out_col_r  <= col_r;
      out_zero_r <= job_r.axis_zero;
      for (int j = 0; j < 4; j++) begin
        out_e_r[j] <= to_entry(m_w[j]);
      end
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.column_index = out_col_r;
  assign out_item.elem0        = out_e_r[0];
  assign out_item.elem1        = out_e_r[1];
  assign out_item.elem2        = out_e_r[2];
  assign out_item.elem3        = out_e_r[3];
  assign out_item.last_column  = (out_col_r == 2'd3);
  assign out_item.axis_zero    = out_zero_r;

endmodule

// ===== hdl/axis_angle_rotation_matrix_top.sv =====
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// Axis-angle to 4x4 rotation matrix, one column per output beat.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  in_item   in    angle, axis_x, axis_y, axis_z
//  out_item  out   column_index, elem0..elem3, last_column, axis_zero
//
//  a non-zero axis runs the back end's root steps with the CORDIC alongside,
//  division steps (one quotient bit per step) and multiply steps on one
//  shared multiplier, then 4 column beats; a zero axis skips to the beats.
//  a two-entry queue lets the front take new items while the back works.
//  reset is synchronous and clears control only. out_item stalls hold the
//  column register and the back end waits.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int ENTRY_WIDTH     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  aarm_in_if.sink     in_item,
  aarm_out_if.source  out_item
);

  logic           q_full, q_push, q_pop, q_avail;
  aarm_pkg::job_t push_job, head_job;

  aarm_front u_front (
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (push_job)
  );

  aarm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (head_job)
  );

  aarm_back #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS),
    .ENTRY_WIDTH     (ENTRY_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_avail  (q_avail),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

endmodule
